// ===== design/bucketed_hash_key_value_map_macros.svh =====
// Assertion macros for the bucketed hash key-value map.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef BUCKETED_HASH_KEY_VALUE_MAP_MACROS_SVH
`define BUCKETED_HASH_KEY_VALUE_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHKV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BHKV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bhkv_pkg.sv =====
// Shared types and codes for the bucketed hash key-value map.
// No dependencies; imported by every module of the block.
package bhkv_pkg;

  localparam int unsigned KEY_W  = 29;
  localparam int unsigned VAL_W  = 29;
  localparam int unsigned STAT_W = 2;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NEW  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== design/bhkv_match.sv =====
// Way match for one bucket row: finds the lowest filled way holding the key.
// Depends on bhkv_pkg.
module bhkv_match
  import bhkv_pkg::*;
#(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned KW    = 29,
  parameter int unsigned FW    = 3,
  parameter int unsigned WAY_W = 2
) (
  input  logic [WAYS-1:0][KW-1:0] row_keys,
  input  logic [FW-1:0]           row_fill,
  input  logic [KW-1:0]           key,
  output logic                    found,
  output logic [WAY_W-1:0]        way
);

  // Scan downwards so the lowest matching way wins.
  always_comb begin
    found = 1'b0;
    way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if ((row_fill > FW'(i)) && (row_keys[i] == key)) begin
        found = 1'b1;
        way   = WAY_W'(i);
      end
    end
  end

endmodule

// ===== design/bucketed_hash_key_value_map.sv =====
// Bucketed hash key-value map: top level with the bucket row memory and control.
// Depends on bhkv_pkg, bhkv_match and bucketed_hash_key_value_map_macros.svh.
//
// A transaction (in_op, in_key, in_value) is taken when start is high and busy is
// low. The bucket is the low log2(BUCKETS) bits of the key (BUCKETS must be a
// power of two). A set updates a matching key or, if there is room, appends a new
// way; a get returns the stored value with out_hit. Each transaction gives exactly
// one result, shown for a single cycle with out_valid high; the receiver cannot
// hold it off, so capture it on that cycle. A transaction first reads the bucket
// row from the single-port row memory, then compares and writes it back; busy is
// high while it compares, so the next transaction is taken only after the last is
// through. The result appears in the cycle after the compare, alongside which the
// next transaction may already be taken. After reset the block clears every
// bucket's fill count, one row per cycle, with busy held high.
module bucketed_hash_key_value_map
  import bhkv_pkg::*;
#(
  parameter int unsigned BUCKETS = 4096,
  parameter int unsigned WAYS    = 4,
  parameter int unsigned ID_BITS = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic [STAT_W-1:0] out_status
);

`include "bucketed_hash_key_value_map_macros.svh"

  // Key bits that take part in compare and storage.
  localparam int unsigned KW    = (ID_BITS < KEY_W) ? ID_BITS : KEY_W;
  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam int unsigned FW    = $clog2(WAYS + 1);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  // Row layout: {fill, values[WAYS], keys[WAYS]}.
  localparam int unsigned ROW_W = WAYS * (KW + VAL_W) + FW;

  // Row memory: one row per bucket.
  logic [ROW_W-1:0] mem [BUCKETS];

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;

  // Held transaction.
  logic             op_r;
  logic [KW-1:0]    key_r;
  logic [VAL_W-1:0] value_r;
  logic [IDX_W-1:0] bucket_r;

  // Memory ports.
  logic             rd_en;
  logic [ROW_W-1:0] rd_row_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wrow;

  // Incoming key, masked to the compared width; bucket from its low bits.
  logic [KW-1:0]    in_key_kw;
  logic [63:0]      in_key_ext;
  logic [IDX_W-1:0] in_bucket;

  // Unpacked row and its modified copy.
  logic [WAYS-1:0][KW-1:0]    row_keys, new_keys;
  logic [WAYS-1:0][VAL_W-1:0] row_vals, new_vals;
  logic [FW-1:0]              row_fill, new_fill;
  logic [ROW_W-1:0]           new_row;

  logic             found;
  logic [WAY_W-1:0] way;
  logic [WAY_W-1:0] ins_idx;
  logic             is_get;
  logic             has_room;
  logic             do_write;

  logic              res_hit;
  logic [VAL_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_read_value_r;
  logic [STAT_W-1:0] out_status_r;

  assign in_key_kw  = in_key[KW-1:0];
  assign in_key_ext = 64'(in_key_kw);
  assign in_bucket  = in_key_ext[IDX_W-1:0];

  assign row_keys = rd_row_r[WAYS*KW-1:0];
  assign row_vals = rd_row_r[WAYS*KW +: WAYS*VAL_W];
  assign row_fill = rd_row_r[ROW_W-1 -: FW];

  bhkv_match #(
    .WAYS  (WAYS),
    .KW    (KW),
    .FW    (FW),
    .WAY_W (WAY_W)
  ) u_match (
    .row_keys (row_keys),
    .row_fill (row_fill),
    .key      (key_r),
    .found    (found),
    .way      (way)
  );

  // Compare stage: decide the result and the row to write back.
  assign is_get   = (op_r == OP_GET);
  assign has_room = (row_fill < FW'(WAYS));
  assign ins_idx  = row_fill[WAY_W-1:0];
  assign do_write = !is_get && (found || has_room);

  always_comb begin
    new_keys = row_keys;
    new_vals = row_vals;
    new_fill = row_fill;
    if (!is_get) begin
      if (found) begin
        new_vals[way] = value_r;
      end else if (has_room) begin
        new_keys[ins_idx] = key_r;
        new_vals[ins_idx] = value_r;
        new_fill          = row_fill + FW'(1);
      end
    end
  end

  assign new_row = {new_fill, new_vals, new_keys};

  always_comb begin
    res_hit    = found;
    res_value  = '1;
    res_status = STATUS_OK;
    if (is_get) begin
      if (found) begin
        res_value = row_vals[way];
      end
    end else if (!found) begin
      res_status = has_room ? STATUS_NEW : STATUS_FULL;
    end
  end

  // Control: clearing pass, then idle / lookup alternation.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = bucket_r;
    mem_wrow  = new_row;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wrow  = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rd_en     = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        mem_we    = do_write;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Hold the accepted transaction for the compare stage.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_r     <= in_op;
      key_r    <= in_key_kw;
      value_r  <= in_value;
      bucket_r <= in_bucket;
    end
  end

  // Row memory: registered read, single write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[in_bucket];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wrow;
    end
  end

  // Result register: strobe for one cycle after the compare stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      out_hit_r        <= res_hit;
      out_read_value_r <= res_value;
      out_status_r     <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  // Checks.
  `BHKV_ASSERT_NXT(a_lookup_emits, state_r == ST_LOOKUP, out_valid_r, "lookup gave no result")
  `BHKV_ASSERT_IMP(a_emit_after_lookup, out_valid_r, $past(state_r) == ST_LOOKUP, "stray result")
  `BHKV_ASSERT_IMP(a_fill_bound, state_r == ST_LOOKUP, row_fill <= FW'(WAYS), "fill beyond ways")
  `BHKV_ASSERT_IMP(a_full_miss, out_valid_r && out_status_r == STATUS_FULL, !out_hit_r && out_read_value_r == '1, "full bucket result inconsistent")
  `BHKV_ASSERT_IMP(a_idle_no_write, state_r == ST_IDLE, !mem_we, "memory written while idle")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the bucketed hash key-value map: directed and random
// set/get traffic, checked against an internal bucket model. Needs bhkv_pkg and the map.

module testbench;
  import bhkv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUCKETS     = 4096;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned ID_BITS     = 29;
  localparam int unsigned BUCKET_BITS = $clog2(BUCKETS);
  localparam int unsigned TAG_W       = KEY_W - BUCKET_BITS;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 8;
  // Covers the worst case, including the fill-count clear.
  localparam int unsigned TIMEOUT_NS  = 2_000_000;
  // Hot pool: a few buckets, each with more distinct keys than ways.
  localparam int unsigned HOT_BUCKETS = 12;
  localparam int unsigned HOT_TAGS    = 6;
  localparam int unsigned HOT_KEYS    = HOT_BUCKETS * HOT_TAGS;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
  } map_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_op = OP_GET;
  logic [KEY_W-1:0]  in_key = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic              out_valid;
  logic              out_hit;
  logic [VAL_W-1:0]  out_read_value;
  logic [STAT_W-1:0] out_status;

  // Mirror of the block's storage; only ways below the fill count are ever looked at.
  logic [KEY_W-1:0]  key_mirror [BUCKETS*WAYS];
  logic [VAL_W-1:0]  value_mirror [BUCKETS*WAYS];
  int unsigned       fill_mirror [BUCKETS];

  map_result_t       pending_results [$];
  logic [KEY_W-1:0]  hot_keys [HOT_KEYS];
  logic [KEY_W-1:0]  written_keys [$];

  bit                gapless = 1'b0;
  int unsigned       fail_count = 0;
  int unsigned       n_sets = 0;
  int unsigned       n_gets = 0;
  int unsigned       n_get_hits = 0;
  int unsigned       n_inserted = 0;
  int unsigned       n_dropped = 0;

  bucketed_hash_key_value_map #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .ID_BITS (ID_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the mirror and return the result the block must give.
  function automatic map_result_t predict_map_access(input logic op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] value);
    map_result_t res;
    int unsigned bucket;
    int unsigned base;
    int unsigned fill;
    int unsigned way;
    bit          found;
    res.hit        = 1'b0;
    res.read_value = '1;
    res.status     = STATUS_OK;
    bucket = key % BUCKETS;
    base   = bucket * WAYS;
    fill   = (fill_mirror[bucket] > WAYS) ? WAYS : fill_mirror[bucket];
    found  = 1'b0;
    way    = 0;
    // Search filled ways in order; the first match wins.
    for (int unsigned i = 0; i < fill; i++) begin
      if (!found && key_mirror[base + i] == key) begin
        found = 1'b1;
        way   = i;
      end
    end
    if (op == OP_GET) begin
      n_gets++;
      if (found) begin
        res.hit        = 1'b1;
        res.read_value = value_mirror[base + way];
        n_get_hits++;
      end
    end else begin
      n_sets++;
      if (found) begin
        // Update in place: hit, but no value is returned on a set.
        res.hit = 1'b1;
        value_mirror[base + way] = value;
      end else if (fill < WAYS) begin
        key_mirror[base + fill]   = key;
        value_mirror[base + fill] = value;
        fill_mirror[bucket]       = fill + 1;
        res.status = STATUS_NEW;
        n_inserted++;
      end else begin
        // Full bucket: drop the new key.
        res.status = STATUS_FULL;
        n_dropped++;
      end
    end
    return res;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // Present one transaction, hold it until the block takes it, then record the
  // expected result. Drop start only when a gap follows, so a back-to-back
  // transaction never sees start lowered and raised in the same step.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int unsigned gap;
    start    <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_map_access(op, key, value));
    if (op == OP_SET) begin
      written_keys.push_back(key);
      if (written_keys.size() > 256) void'(written_keys.pop_front());
    end
    gap = pick_gap();
    if (gap != 0) begin
      // Scramble the payload while idle: the block must ignore it.
      start    <= 1'b0;
      in_op    <= 1'($urandom_range(0, 1));
      in_key   <= KEY_W'($urandom);
      in_value <= VAL_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Empty map, extreme keys and values, insert, update and hit.
  task automatic test_extreme_keys();
    send_request(OP_GET, '0, '0);
    send_request(OP_GET, '1, '1);
    send_request(OP_SET, '0, '0);
    send_request(OP_SET, '1, '1);
    send_request(OP_GET, '0, '1);
    send_request(OP_GET, '1, '0);
    send_request(OP_SET, '0, 29'h1555_5555);
    send_request(OP_GET, '0, '0);
  endtask

  // Fill one bucket, overflow it, then update and read within the full bucket.
  task automatic test_bucket_overflow();
    logic [BUCKET_BITS-1:0] b;
    logic [KEY_W-1:0]       k [5];
    b = 12'h0A5;
    k[0] = {17'h00001, b};
    k[1] = {17'h1FFFF, b};
    k[2] = {17'h10000, b};
    k[3] = {17'h0ABCD, b};
    k[4] = {17'h05432, b};
    for (int i = 0; i < 4; i++) send_request(OP_SET, k[i], pick_value());
    send_request(OP_SET, k[4], 29'h0F0F_0F0F);       // dropped, bucket full
    send_request(OP_GET, k[4], '0);                  // dropped key misses
    send_request(OP_SET, k[3], 29'h1234_5678);       // update in full bucket
    send_request(OP_GET, k[3], '1);
    send_request(OP_GET, k[0], '0);
    send_request(OP_GET, {17'h0FFFF, b}, '0);        // same bucket, top bit differs
    send_request(OP_GET, k[1], '0);
  endtask

  task automatic build_hot_keys();
    logic [BUCKET_BITS-1:0] b;
    logic [TAG_W-1:0]       tag;
    for (int i = 0; i < HOT_BUCKETS; i++) begin
      b = BUCKET_BITS'($urandom);
      for (int t = 0; t < HOT_TAGS; t++) begin
        tag = TAG_W'($urandom);
        hot_keys[i*HOT_TAGS + t] = {tag, b};
      end
    end
  endtask

  // Dense traffic on a few buckets: hits, updates, fills and drops.
  task automatic test_hot_bucket_traffic(input int unsigned count);
    logic             op;
    logic [KEY_W-1:0] key;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 0) build_hot_keys();
      if (i % 64 == 0) gapless = ($urandom_range(0, 3) == 0);
      op  = ($urandom_range(0, 1) == 0) ? OP_SET : OP_GET;
      key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                        : hot_keys[$urandom_range(0, HOT_KEYS - 1)];
      send_request(op, key, pick_value());
    end
    gapless = 1'b0;
  endtask

  // Keys over the whole range, with reads of recently written keys for hits.
  task automatic test_scattered_keys(input int unsigned count);
    logic             op;
    logic [KEY_W-1:0] key;
    for (int unsigned i = 0; i < count; i++) begin
      op  = ($urandom_range(0, 1) == 0) ? OP_SET : OP_GET;
      key = KEY_W'($urandom);
      if (op == OP_GET && written_keys.size() != 0 && $urandom_range(0, 1) == 0)
        key = written_keys[$urandom_range(0, written_keys.size() - 1)];
      send_request(op, key, pick_value());
    end
  endtask

  // Compare every result against the oldest expectation, on the cycle it is shown.
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && $isunknown(out_valid)) begin
      $error("out_valid is unknown");
      fail_count++;
    end else if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: hit %0d read_value 0x%0h status %0d",
               out_hit, out_read_value, out_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
          fail_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("out_read_value: expected 0x%0h, got 0x%0h", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // Hold reset, then release it on a rising edge; the block clears its fill
    // counts afterwards with busy high, which the first transaction waits out.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_keys();
    test_bucket_overflow();
    test_hot_bucket_traffic(1000);
    test_scattered_keys(280);

    // Idle the input, drain the expectations, then watch for stray results.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d sets (%0d inserted, %0d dropped on a full bucket, rest updates)",
             n_sets, n_inserted, n_dropped);
    $display("and %0d gets (%0d hits), with random gaps and back-to-back bursts.",
             n_gets, n_get_hits);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== bucketed_hash_key_value_map.f =====
+incdir+design
design/bhkv_pkg.sv
design/bhkv_match.sv
design/bucketed_hash_key_value_map.sv
sim/testbench.sv
